@@ hw/rtl/least_squares_line_fit_assert.svh @@
// ----------------------------------------------------------------------------
// least_squares_line_fit assertion macros
// Shared concurrent assertion forms for the line-fit block.
// ----------------------------------------------------------------------------
`ifndef LEAST_SQUARES_LINE_FIT_ASSERT_SVH
`define LEAST_SQUARES_LINE_FIT_ASSERT_SVH

// same-cycle implication
`define LSLF_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("line fit assertion failed");

// next-cycle implication
`define LSLF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("line fit assertion failed");

`endif

@@ hw/rtl/lslf_pkg.sv @@
// ----------------------------------------------------------------------------
// lslf_pkg
// Types and constants of the least-squares line fit.
// ----------------------------------------------------------------------------
`default_nettype none

package lslf_pkg;

    localparam int SAMPLE_W = 16;
    localparam int RES_W    = 48;
    localparam int COUNT_W  = 11;
    localparam int STATUS_W = 2;
    localparam int Q_FRAC   = 16;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] x_value;
        logic signed [SAMPLE_W-1:0] y_value;
        logic                       last_point;
    } t_point;

    typedef struct packed {
        logic signed [RES_W-1:0] slope;
        logic signed [RES_W-1:0] intercept;
        logic [COUNT_W-1:0]      point_count;
        logic [STATUS_W-1:0]     fit_status;
    } t_fit;

    typedef enum logic [STATUS_W-1:0] {
        FS_OK      = 2'd0,
        FS_DEGEN   = 2'd1,
        FS_DROPPED = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        ST_ACC,
        ST_MLOAD,
        ST_MUL,
        ST_PREP,
        ST_CHECK,
        ST_DLOAD,
        ST_DIV,
        ST_OUT
    } t_state;

    // products: n*Sxx, Sx*Sx, n*Sxy, Sx*Sy, Sxx*Sy, Sx*Sxy
    typedef enum logic [2:0] {
        PR_N_XX,
        PR_X_X,
        PR_N_XY,
        PR_X_Y,
        PR_XX_Y,
        PR_X_XY
    } t_prod;

    typedef enum logic {
        QT_SLOPE,
        QT_ICPT
    } t_quot;

    typedef struct packed {
        logic  accumulate;
        logic  mul_load;
        logic  mul_step;
        logic  mul_store;
        logic  prep;
        logic  div_load;
        logic  div_step;
        logic  div_store;
        logic  result_load;
        t_prod prod_sel;
        t_quot quot_sel;
    } t_cmd;

    typedef struct packed {
        logic mul_done;
        logic div_done;
        logic degenerate;
    } t_sts;

endpackage

`default_nettype wire

@@ hw/rtl/lslf_stream_if.sv @@
// ----------------------------------------------------------------------------
// lslf_stream_if
// Valid/ready channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface lslf_stream_if #(
    parameter type t_payload = logic
) ();
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/least_squares_line_fit.sv @@
// After the last point the fit forms six products on a bit-serial multiplier and,
// unless the set is degenerate, two quotients on a bit-serial divider.
// Points of a set are taken one per cycle; the next set waits for the fit.
// Synchronous active-low reset clears the sums, point counter and output valid.
// ----------------------------------------------------------------------------
// least_squares_line_fit
// Streaming least-squares straight-line fit with Q32.16 slope and intercept.
// ----------------------------------------------------------------------------
`default_nettype none

module least_squares_line_fit #(
    parameter int MAX_POINTS = 1024
) (
    input  wire           i_clk,
    input  wire           i_rst_n,
    lslf_stream_if.sink   i_point,
    lslf_stream_if.source o_fit
);
    import lslf_pkg::*;

    t_cmd   cmd;
    t_sts   sts;
    t_fit   fit;
    t_point pt;

    assign pt = i_point.payload;

    lslf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_point.valid),
        .i_in_last   (pt.last_point),
        .o_in_ready  (i_point.ready),
        .o_out_valid (o_fit.valid),
        .i_out_ready (o_fit.ready),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    lslf_dpath #(
        .MAX_POINTS (MAX_POINTS)
    ) u_dpath (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (cmd),
        .o_sts     (sts),
        .i_x_value (pt.x_value),
        .i_y_value (pt.y_value),
        .o_fit     (fit)
    );

    assign o_fit.payload = fit;

`include "least_squares_line_fit_assert.svh"

    `LSLF_ASSERT_NEXT(a_busy_after_last, i_clk, i_rst_n, i_point.valid && i_point.ready && pt.last_point, !i_point.ready)
    `LSLF_ASSERT_IMPLY(a_degen_zero, i_clk, i_rst_n, o_fit.valid && (fit.fit_status == FS_DEGEN), (fit.slope == '0) && (fit.intercept == '0))
    `LSLF_ASSERT_IMPLY(a_result_after_busy, i_clk, i_rst_n, $rose(o_fit.valid), $past(!i_point.ready))

endmodule

`default_nettype wire

@@ hw/rtl/lslf_ctrl.sv @@
// ----------------------------------------------------------------------------
// lslf_ctrl
// Sequencer: accumulate, six serial products, two serial divisions (skipped if degenerate), output.
// ----------------------------------------------------------------------------
`default_nettype none

module lslf_ctrl (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_in_valid,
    input  wire              i_in_last,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  wire              i_out_ready,
    output lslf_pkg::t_cmd   o_cmd,
    input  lslf_pkg::t_sts   i_sts
);
    import lslf_pkg::*;

    t_state r_state, n_state;
    t_prod  r_prod, n_prod;
    t_quot  r_quot, n_quot;
    logic   r_valid, n_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_ACC;
            r_prod  <= PR_N_XX;
            r_quot  <= QT_SLOPE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_prod  <= n_prod;
            r_quot  <= n_quot;
            r_valid <= n_valid;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_prod     = r_prod;
        n_quot     = r_quot;
        n_valid    = r_valid && !i_out_ready;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        o_cmd.prod_sel = r_prod;
        o_cmd.quot_sel = r_quot;
        unique case (r_state)
            ST_ACC: begin
                o_in_ready = i_rst_n;
                if (i_in_valid && i_rst_n) begin
                    o_cmd.accumulate = 1'b1;
                    if (i_in_last) begin
                        n_prod  = PR_N_XX;
                        n_state = ST_MLOAD;
                    end
                end
            end
            ST_MLOAD: begin
                o_cmd.mul_load = 1'b1;
                n_state = ST_MUL;
            end
            ST_MUL: begin
                if (i_sts.mul_done) begin
                    o_cmd.mul_store = 1'b1;
                    if (r_prod == PR_X_XY) begin
                        n_state = ST_PREP;
                    end else begin
                        n_prod  = t_prod'(r_prod + 3'd1);
                        n_state = ST_MLOAD;
                    end
                end else begin
                    o_cmd.mul_step = 1'b1;
                end
            end
            ST_PREP: begin
                o_cmd.prep = 1'b1;
                n_state = ST_CHECK;
            end
            ST_CHECK: begin
                n_quot = QT_SLOPE;
                if (i_sts.degenerate) begin
                    n_state = ST_OUT;
                end else begin
                    n_state = ST_DLOAD;
                end
            end
            ST_DLOAD: begin
                o_cmd.div_load = 1'b1;
                n_state = ST_DIV;
            end
            ST_DIV: begin
                if (i_sts.div_done) begin
                    o_cmd.div_store = 1'b1;
                    if (r_quot == QT_ICPT) begin
                        n_state = ST_OUT;
                    end else begin
                        n_quot  = QT_ICPT;
                        n_state = ST_DLOAD;
                    end
                end else begin
                    o_cmd.div_step = 1'b1;
                end
            end
            ST_OUT: begin
                if (!r_valid || i_out_ready) begin
                    o_cmd.result_load = 1'b1;
                    n_valid = 1'b1;
                    n_state = ST_ACC;
                end
            end
            default: begin
                n_state = ST_ACC;
            end
        endcase
    end

    assign o_out_valid = r_valid;

endmodule

`default_nettype wire

@@ hw/rtl/lslf_dpath.sv @@
// ----------------------------------------------------------------------------
// lslf_dpath
// Running sums, shift-add multiplier, restoring divider and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module lslf_dpath #(
    parameter int MAX_POINTS = 1024
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  lslf_pkg::t_cmd                       i_cmd,
    output lslf_pkg::t_sts                       o_sts,
    input  wire signed [lslf_pkg::SAMPLE_W-1:0]  i_x_value,
    input  wire signed [lslf_pkg::SAMPLE_W-1:0]  i_y_value,
    output lslf_pkg::t_fit                       o_fit
);
    import lslf_pkg::*;

    localparam int CW   = $clog2(MAX_POINTS + 1);
    localparam int SXW  = 2 * SAMPLE_W + 1 - SAMPLE_W + CW;
    localparam int OPW  = 2 * SAMPLE_W + CW;
    localparam int PW   = 2 * OPW;
    localparam int SPW  = PW + 1;
    localparam int NUMW = SPW + 1;
    localparam int NW   = NUMW + Q_FRAC;
    localparam int CNTW = $clog2(NW + 1);
    localparam int NPR  = 6;

    localparam logic [RES_W-1:0] LIM_POS = {1'b0, {(RES_W-1){1'b1}}};
    localparam logic [RES_W-1:0] LIM_NEG = {1'b1, {(RES_W-1){1'b0}}};

    // running sums
    logic [CW-1:0]          r_total;
    logic signed [SXW-1:0]  r_sx, r_sy;
    logic signed [OPW-1:0]  r_sxx, r_sxy;
    logic                   r_ovf;

    logic signed [2*SAMPLE_W-1:0] xy, xx;

    assign xy = i_x_value * i_y_value;
    assign xx = i_x_value * i_x_value;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.result_load) begin
            r_total <= '0;
            r_sx    <= '0;
            r_sy    <= '0;
            r_sxx   <= '0;
            r_sxy   <= '0;
            r_ovf   <= 1'b0;
        end else if (i_cmd.accumulate) begin
            if (r_total < CW'(MAX_POINTS)) begin
                r_total <= r_total + CW'(1);
                r_sx    <= r_sx + {{(SXW-SAMPLE_W){i_x_value[SAMPLE_W-1]}}, i_x_value};
                r_sy    <= r_sy + {{(SXW-SAMPLE_W){i_y_value[SAMPLE_W-1]}}, i_y_value};
                r_sxy   <= r_sxy + {{(OPW-2*SAMPLE_W){xy[2*SAMPLE_W-1]}}, xy};
                r_sxx   <= r_sxx + {{(OPW-2*SAMPLE_W){xx[2*SAMPLE_W-1]}}, xx};
            end else begin
                r_ovf <= 1'b1;
            end
        end
    end

    // operand select
    logic signed [OPW-1:0] n_ext, sx_ext, sy_ext, op_a, op_b;
    logic [OPW-1:0]        mag_a, mag_b;

    assign n_ext  = {{(OPW-CW){1'b0}}, r_total};
    assign sx_ext = {{(OPW-SXW){r_sx[SXW-1]}}, r_sx};
    assign sy_ext = {{(OPW-SXW){r_sy[SXW-1]}}, r_sy};

    always_comb begin
        unique case (i_cmd.prod_sel)
            PR_N_XX: begin op_a = n_ext;  op_b = r_sxx;  end
            PR_X_X:  begin op_a = sx_ext; op_b = sx_ext; end
            PR_N_XY: begin op_a = n_ext;  op_b = r_sxy;  end
            PR_X_Y:  begin op_a = sx_ext; op_b = sy_ext; end
            PR_XX_Y: begin op_a = r_sxx;  op_b = sy_ext; end
            PR_X_XY: begin op_a = sx_ext; op_b = r_sxy;  end
            default: begin op_a = '0;     op_b = '0;     end
        endcase
    end

    assign mag_a = op_a[OPW-1] ? OPW'(-op_a) : OPW'(op_a);
    assign mag_b = op_b[OPW-1] ? OPW'(-op_b) : OPW'(op_b);

    // shift-add multiplier, one multiplier bit per cycle
    logic [PW-1:0]         r_mcand, r_macc;
    logic [OPW-1:0]        r_mplier;
    logic                  r_mneg;
    logic [CNTW-1:0]       r_cnt;
    logic signed [SPW-1:0] r_prod [NPR];

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_load) begin
            r_mcand  <= {{(PW-OPW){1'b0}}, mag_a};
            r_mplier <= mag_b;
            r_macc   <= '0;
            r_mneg   <= op_a[OPW-1] ^ op_b[OPW-1];
        end else if (i_cmd.mul_step) begin
            if (r_mplier[0]) begin
                r_macc <= r_macc + r_mcand;
            end
            r_mcand  <= {r_mcand[PW-2:0], 1'b0};
            r_mplier <= {1'b0, r_mplier[OPW-1:1]};
        end
        if (i_cmd.mul_store) begin
            r_prod[i_cmd.prod_sel] <= r_mneg ? -$signed({1'b0, r_macc})
                                             : $signed({1'b0, r_macc});
        end
    end

    // shared step counter
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_load || i_cmd.div_load) begin
            r_cnt <= '0;
        end else if (i_cmd.mul_step || i_cmd.div_step) begin
            r_cnt <= r_cnt + CNTW'(1);
        end
    end

    // denominator and numerators
    logic signed [NUMW-1:0] den_c;
    logic signed [NUMW-1:0] r_den, r_num_m, r_num_b;
    logic                   r_deg;
    t_status                r_status;

    assign den_c = {r_prod[PR_N_XX][SPW-1], r_prod[PR_N_XX]}
                 - {r_prod[PR_X_X][SPW-1], r_prod[PR_X_X]};

    always_ff @(posedge i_clk) begin
        if (i_cmd.prep) begin
            r_den   <= den_c;
            r_num_m <= {r_prod[PR_N_XY][SPW-1], r_prod[PR_N_XY]}
                     - {r_prod[PR_X_Y][SPW-1], r_prod[PR_X_Y]};
            r_num_b <= {r_prod[PR_XX_Y][SPW-1], r_prod[PR_XX_Y]}
                     - {r_prod[PR_X_XY][SPW-1], r_prod[PR_X_XY]};
            r_deg   <= (r_total < CW'(2)) || den_c[NUMW-1] || (den_c == '0);
            if ((r_total < CW'(2)) || den_c[NUMW-1] || (den_c == '0)) begin
                r_status <= FS_DEGEN;
            end else if (r_ovf) begin
                r_status <= FS_DROPPED;
            end else begin
                r_status <= FS_OK;
            end
        end
    end

    // restoring divider, one quotient bit per cycle
    logic signed [NUMW-1:0] num_sel;
    logic [NUMW-1:0]        num_mag;
    logic [NW-1:0]          r_dvd;
    logic [NUMW-1:0]        r_rem;
    logic [RES_W-1:0]       r_q;
    logic                   r_big, r_dneg;
    logic [NUMW:0]          rem_sh, rem_diff;
    logic                   rem_ge;
    logic [RES_W-1:0]       lim, q_sat, q_res;
    logic signed [RES_W-1:0] r_slope, r_icpt;

    assign num_sel  = (i_cmd.quot_sel == QT_ICPT) ? r_num_b : r_num_m;
    assign num_mag  = num_sel[NUMW-1] ? NUMW'(-num_sel) : NUMW'(num_sel);
    assign rem_sh   = {r_rem, r_dvd[NW-1]};
    assign rem_diff = rem_sh - {1'b0, r_den};
    assign rem_ge   = !rem_diff[NUMW] || (rem_sh == {1'b0, r_den});
    assign lim      = r_dneg ? LIM_NEG : LIM_POS;
    assign q_sat    = (r_big || (r_q > lim)) ? lim : r_q;
    assign q_res    = r_dneg ? RES_W'(-q_sat) : q_sat;

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_load) begin
            r_dvd  <= {num_mag, {Q_FRAC{1'b0}}};
            r_rem  <= '0;
            r_q    <= '0;
            r_big  <= 1'b0;
            r_dneg <= num_sel[NUMW-1];
        end else if (i_cmd.div_step) begin
            r_rem  <= rem_ge ? NUMW'(rem_diff) : NUMW'(rem_sh);
            r_q    <= {r_q[RES_W-2:0], rem_ge};
            r_big  <= r_big | r_q[RES_W-1];
            r_dvd  <= {r_dvd[NW-2:0], 1'b0};
        end
        if (i_cmd.div_store) begin
            if (i_cmd.quot_sel == QT_ICPT) begin
                r_icpt <= $signed(q_res);
            end else begin
                r_slope <= $signed(q_res);
            end
        end
    end

    // result register
    t_fit r_fit;

    always_ff @(posedge i_clk) begin
        if (i_cmd.result_load) begin
            r_fit.slope       <= r_deg ? '0 : r_slope;
            r_fit.intercept   <= r_deg ? '0 : r_icpt;
            r_fit.point_count <= COUNT_W'({{COUNT_W{1'b0}}, r_total});
            r_fit.fit_status  <= r_status;
        end
    end

    assign o_fit            = r_fit;
    assign o_sts.mul_done   = (r_cnt == CNTW'(OPW));
    assign o_sts.div_done   = (r_cnt == CNTW'(NW));
    assign o_sts.degenerate = r_deg;

endmodule

`default_nettype wire
